// ===== hw/rtl/spa_pkg.sv =====
// Shared constants, codes, types and helpers of the slot pool allocator.
`default_nettype none
package spa_pkg;

    localparam int SLOTS_DEF       = 256;
    localparam int ALIGN_BYTES_DEF = 16;
    localparam int GEN_BITS_DEF    = 16;

    localparam int OP_W     = 3;
    localparam int IDX_W    = 8;
    localparam int MGEN_W   = 16;
    localparam int LIMIT_W  = 16;
    localparam int STATUS_W = 2;
    localparam int OFF_W    = 20;
    localparam int CNT_W    = 9;
    localparam int OBJ_W    = 13;
    localparam int STRIDE_W = 14;

    localparam logic [OBJ_W-1:0] OBJ_RESET = OBJ_W'(16);

    localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
    localparam logic [OP_W-1:0] OP_MARK  = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;
    localparam logic [OP_W-1:0] OP_SWEEP = 3'd5;
    localparam logic [OP_W-1:0] OP_RESET = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd2;

    typedef struct packed {
        logic                settling;
        logic [STRIDE_W-1:0] stride;
    } t_stride_stat;

    // bits needed to hold the value n
    function automatic int bits_for(input int n);
        int b;
        b = 1;
        while ((n >> b) != 0) begin
            b = b + 1;
        end
        return b;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/spa_stride.sv =====
// Object size register and aligned slot stride computation.
`default_nettype none
module spa_stride #(
    parameter int ALIGN_BYTES = spa_pkg::ALIGN_BYTES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_valid,
    input  wire logic [spa_pkg::OBJ_W-1:0] i_cfg_data,
    output spa_pkg::t_stride_stat         o_stat
);

    // stride = floor((size + A - 1) / A) * A, quotient by exact reciprocal
    localparam int NW = spa_pkg::STRIDE_W;
    localparam int AB = spa_pkg::bits_for(ALIGN_BYTES);
    localparam int K  = NW + AB;
    localparam int MW = K + 1;
    localparam logic [63:0] M64 =
        ((64'd1 << K) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
    localparam logic [MW-1:0] M_LP = MW'(M64);

    logic [spa_pkg::OBJ_W-1:0] r_object_size;
    logic                      r_settle;
    logic [NW+MW-1:0]          r_prod;
    logic [NW-1:0]             r_stride;
    logic [NW-1:0]             sum;
    logic [NW+MW-K-1:0]        quot;

    assign sum  = NW'(r_object_size) + NW'(ALIGN_BYTES - 1);
    assign quot = r_prod[NW+MW-1:K];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_object_size <= spa_pkg::OBJ_RESET;
            r_settle      <= 1'b1;
        end else begin
            r_settle <= i_cfg_valid;
            if (i_cfg_valid) begin
                r_object_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= {{MW{1'b0}}, sum} * {{NW{1'b0}}, M_LP};
        r_stride <= NW'(32'(quot) * ALIGN_BYTES);
    end

    assign o_stat.settling = r_settle;
    assign o_stat.stride   = r_stride;

endmodule
`default_nettype wire

// ===== hw/rtl/slot_pool_allocator_mark_sweep_unit.sv =====
// Top level: slot pool allocator with LIFO free list and mark/sweep.
//
//  channel   dir  handshake                 beat
//  command   in   start & !busy             opcode, slot_index, mark_generation, sweep_limit
//  result    out  o_done (one cycle)        status, granted_slot, byte_offset, is_kept,
//                                           freed_count, used_count
//  config    in   i_cfg_valid & o_cfg_ready object_size
//
// Alloc, free, mark, query and unused opcodes do a link/mark memory read, then
// evaluate and write back in S_EXEC. Sweep and clear marks walk both memories;
// reset pool refills the link memory.
// After reset a clearing pass fills both memories with busy high.
// A config write holds busy while the stride settles.
// Results are never held off; o_done pulses for one cycle and result fields hold.
`default_nettype none
module slot_pool_allocator_mark_sweep_unit #(
    parameter int SLOTS       = spa_pkg::SLOTS_DEF,
    parameter int ALIGN_BYTES = spa_pkg::ALIGN_BYTES_DEF,
    parameter int GEN_BITS    = spa_pkg::GEN_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output      logic                        busy,
    input  wire logic [spa_pkg::OP_W-1:0]    i_opcode,
    input  wire logic [spa_pkg::IDX_W-1:0]   i_slot_index,
    input  wire logic [spa_pkg::MGEN_W-1:0]  i_mark_generation,
    input  wire logic [spa_pkg::LIMIT_W-1:0] i_sweep_limit,
    output      logic                        o_done,
    output      logic [spa_pkg::STATUS_W-1:0] o_status,
    output      logic [spa_pkg::IDX_W-1:0]   o_granted_slot,
    output      logic [spa_pkg::OFF_W-1:0]   o_byte_offset,
    output      logic                        o_is_kept,
    output      logic [spa_pkg::CNT_W-1:0]   o_freed_count,
    output      logic [spa_pkg::CNT_W-1:0]   o_used_count,
    input  wire logic                        i_cfg_valid,
    output      logic                        o_cfg_ready,
    input  wire logic [spa_pkg::OBJ_W-1:0]   i_cfg_data
);

    localparam int AW = spa_pkg::bits_for(SLOTS - 1);
    localparam int CW = spa_pkg::bits_for(SLOTS);
    localparam int PW = AW + spa_pkg::STRIDE_W;
    localparam logic [CW-1:0] LINK_NULL = CW'(SLOTS);
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

    typedef struct packed {
        logic          alloc;
        logic [CW-1:0] link;
    } t_link_ent;

    typedef struct packed {
        logic                keep;
        logic [GEN_BITS-1:0] gen;
    } t_mark_ent;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_FILL
    } t_state;

    spa_pkg::t_stride_stat stride_st;

    spa_stride #(
        .ALIGN_BYTES(ALIGN_BYTES)
    ) u_stride (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stride_st)
    );

    t_link_ent mem_a [SLOTS];
    t_mark_ent mem_b [SLOTS];
    t_link_ent q_a;
    t_mark_ent q_b;

    logic          we_a, we_b;
    logic [AW-1:0] wa_addr, wb_addr, ra_addr;
    t_link_ent     wa_data;
    t_mark_ent     wb_data;

    t_state                        r_state, n_state;
    logic                          r_init, n_init;
    logic [AW-1:0]                 r_addr, n_addr;
    logic [CW-1:0]                 r_head, n_head;
    logic [CW-1:0]                 r_count, n_count;
    logic [CW-1:0]                 r_freed, n_freed;
    logic [spa_pkg::OP_W-1:0]      r_op, n_op;
    logic [AW-1:0]                 r_idx, n_idx;
    logic                          r_in_range, n_in_range;
    logic [GEN_BITS-1:0]           r_gen, n_gen;
    logic [spa_pkg::LIMIT_W-1:0]   r_limit, n_limit;

    logic                          r_done, n_done;
    logic [spa_pkg::STATUS_W-1:0]  r_status, n_status;
    logic [spa_pkg::IDX_W-1:0]     r_slot, n_slot;
    logic [spa_pkg::OFF_W-1:0]     r_offset, n_offset;
    logic                          r_kept, n_kept;
    logic [spa_pkg::CNT_W-1:0]     r_freed_out, n_freed_out;
    logic [spa_pkg::CNT_W-1:0]     r_used, n_used;

    logic          accept;
    logic [PW-1:0] off_full;
    logic          sweep_hit;

    assign busy        = (r_state != S_IDLE) || stride_st.settling;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    assign off_full  = PW'(r_head[AW-1:0]) * PW'(stride_st.stride);
    assign sweep_hit = q_a.alloc && !q_b.keep && (32'(q_b.gen) <= 32'(r_limit));

    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_addr      = r_addr;
        n_head      = r_head;
        n_count     = r_count;
        n_freed     = r_freed;
        n_op        = r_op;
        n_idx       = r_idx;
        n_in_range  = r_in_range;
        n_gen       = r_gen;
        n_limit     = r_limit;
        n_done      = 1'b0;
        n_status    = r_status;
        n_slot      = r_slot;
        n_offset    = r_offset;
        n_kept      = r_kept;
        n_freed_out = r_freed_out;
        n_used      = r_used;
        we_a        = 1'b0;
        we_b        = 1'b0;
        wa_addr     = r_addr;
        wb_addr     = r_addr;
        wa_data     = '0;
        wb_data     = '0;
        ra_addr     = r_addr + AW'(1);

        case (r_state)
            S_IDLE: begin
                if (i_opcode == spa_pkg::OP_ALLOC) begin
                    ra_addr = r_head[AW-1:0];
                end else if (i_opcode inside {spa_pkg::OP_SWEEP, spa_pkg::OP_CLEAR}) begin
                    ra_addr = '0;
                end else begin
                    ra_addr = AW'(i_slot_index);
                end
                if (accept) begin
                    n_op       = i_opcode;
                    n_idx      = AW'(i_slot_index);
                    n_in_range = 32'(i_slot_index) < SLOTS;
                    n_gen      = GEN_BITS'(i_mark_generation);
                    n_limit    = i_sweep_limit;
                    n_addr     = '0;
                    n_freed    = '0;
                    if (i_opcode inside {spa_pkg::OP_SWEEP, spa_pkg::OP_CLEAR}) begin
                        n_state = S_WALK;
                    end else if (i_opcode == spa_pkg::OP_RESET) begin
                        n_state = S_FILL;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                n_status = spa_pkg::ST_OK;
                n_slot   = '0;
                n_offset = '0;
                n_kept   = 1'b0;
                case (r_op)
                    spa_pkg::OP_ALLOC: begin
                        if (r_head == LINK_NULL) begin
                            n_status = spa_pkg::ST_EXHAUSTED;
                        end else begin
                            we_a          = 1'b1;
                            wa_addr       = r_head[AW-1:0];
                            wa_data.alloc = 1'b1;
                            wa_data.link  = q_a.link;
                            n_head        = q_a.link;
                            n_count       = r_count + CW'(1);
                            n_slot        = spa_pkg::IDX_W'(r_head[AW-1:0]);
                            n_offset      = spa_pkg::OFF_W'(off_full);
                        end
                    end
                    spa_pkg::OP_FREE: begin
                        if (r_in_range && q_a.alloc) begin
                            we_a          = 1'b1;
                            wa_addr       = r_idx;
                            wa_data.alloc = 1'b0;
                            wa_data.link  = r_head;
                            n_head        = CW'(r_idx);
                            n_count       = r_count - CW'(1);
                        end else begin
                            n_status = spa_pkg::ST_BAD_FREE;
                        end
                    end
                    spa_pkg::OP_MARK: begin
                        if (r_in_range) begin
                            we_b         = 1'b1;
                            wb_addr      = r_idx;
                            wb_data.keep = 1'b1;
                            wb_data.gen  = r_gen;
                        end
                    end
                    spa_pkg::OP_QUERY: begin
                        n_kept = r_in_range && q_b.keep;
                    end
                    default: begin
                    end
                endcase
                n_done      = 1'b1;
                n_freed_out = '0;
                n_used      = spa_pkg::CNT_W'(n_count);
                n_state     = S_IDLE;
            end
            S_WALK: begin
                if (r_op == spa_pkg::OP_SWEEP) begin
                    if (sweep_hit) begin
                        we_a          = 1'b1;
                        wa_data.alloc = 1'b0;
                        wa_data.link  = r_head;
                        n_head        = CW'(r_addr);
                        n_count       = r_count - CW'(1);
                        n_freed       = r_freed + CW'(1);
                    end
                end else begin
                    we_b         = 1'b1;
                    wb_data.keep = 1'b0;
                    wb_data.gen  = q_b.gen;
                end
                n_addr = r_addr + AW'(1);
                if (r_addr == LAST_SLOT) begin
                    n_done      = 1'b1;
                    n_status    = spa_pkg::ST_OK;
                    n_slot      = '0;
                    n_offset    = '0;
                    n_kept      = 1'b0;
                    n_freed_out = spa_pkg::CNT_W'(n_freed);
                    n_used      = spa_pkg::CNT_W'(n_count);
                    n_state     = S_IDLE;
                end
            end
            S_FILL: begin
                we_a          = 1'b1;
                wa_data.alloc = 1'b0;
                wa_data.link  = CW'(r_addr) + CW'(1);
                we_b          = r_init;
                n_addr        = r_addr + AW'(1);
                if (r_addr == LAST_SLOT) begin
                    n_head      = '0;
                    n_count     = '0;
                    n_init      = 1'b0;
                    n_done      = !r_init;
                    n_status    = spa_pkg::ST_OK;
                    n_slot      = '0;
                    n_offset    = '0;
                    n_kept      = 1'b0;
                    n_freed_out = '0;
                    n_used      = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            mem_a[wa_addr] <= wa_data;
        end
        q_a <= mem_a[ra_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            mem_b[wb_addr] <= wb_data;
        end
        q_b <= mem_b[ra_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_init  <= 1'b1;
            r_addr  <= '0;
            r_head  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_addr  <= n_addr;
            r_head  <= n_head;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_freed     <= n_freed;
        r_op        <= n_op;
        r_idx       <= n_idx;
        r_in_range  <= n_in_range;
        r_gen       <= n_gen;
        r_limit     <= n_limit;
        r_status    <= n_status;
        r_slot      <= n_slot;
        r_offset    <= n_offset;
        r_kept      <= n_kept;
        r_freed_out <= n_freed_out;
        r_used      <= n_used;
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_granted_slot = r_slot;
    assign o_byte_offset  = r_offset;
    assign o_is_kept      = r_kept;
    assign o_freed_count  = r_freed_out;
    assign o_used_count   = r_used;

`ifndef NO_ASSERTIONS
    a_no_done_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_done)
        else $error("result strobe right after a command beat");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LINK_NULL)
        else $error("in-use count beyond pool size");

    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_op == spa_pkg::OP_ALLOC && r_head != LINK_NULL)
        |=> (r_count == $past(r_count) + CW'(1)) && o_done)
        else $error("alloc did not bump count and report");

    a_list_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_head == LINK_NULL) == (r_count == LINK_NULL)))
        else $error("free list head and in-use count disagree");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_slot_pool_allocator_mark_sweep_unit.sv =====
`timescale 1ns / 1ps
// Testbench for the slot pool allocator: directed and random commands checked against a pool model.
module tb_slot_pool_allocator_mark_sweep_unit;

    localparam logic [spa_pkg::OP_W-1:0] OP_NOP = 3'd7;
    localparam int NSLOT        = spa_pkg::SLOTS_DEF;
    localparam int ALIGN        = spa_pkg::ALIGN_BYTES_DEF;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 2 * NSLOT + 50;
    localparam int BACKLOG_MAX  = 4;

    typedef enum int {MIX_BALANCED = 0, MIX_FILL = 1, MIX_RECLAIM = 2} t_mix;

    typedef struct packed {
        logic                        is_cfg;
        logic [spa_pkg::OBJ_W-1:0]   obj_size;
        logic [spa_pkg::OP_W-1:0]    op;
        logic [spa_pkg::IDX_W-1:0]   idx;
        logic [spa_pkg::MGEN_W-1:0]  gen;
        logic [spa_pkg::LIMIT_W-1:0] lim;
    } t_pool_cmd;

    typedef struct packed {
        logic [spa_pkg::STATUS_W-1:0] status;
        logic [spa_pkg::IDX_W-1:0]    slot;
        logic [spa_pkg::OFF_W-1:0]    offset;
        logic                         kept;
        logic [spa_pkg::CNT_W-1:0]    freed;
        logic [spa_pkg::CNT_W-1:0]    used;
    } t_pool_res;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [spa_pkg::OP_W-1:0]     i_opcode = '0;
    logic [spa_pkg::IDX_W-1:0]    i_slot_index = '0;
    logic [spa_pkg::MGEN_W-1:0]   i_mark_generation = '0;
    logic [spa_pkg::LIMIT_W-1:0]  i_sweep_limit = '0;
    logic                         o_done;
    logic [spa_pkg::STATUS_W-1:0] o_status;
    logic [spa_pkg::IDX_W-1:0]    o_granted_slot;
    logic [spa_pkg::OFF_W-1:0]    o_byte_offset;
    logic                         o_is_kept;
    logic [spa_pkg::CNT_W-1:0]    o_freed_count;
    logic [spa_pkg::CNT_W-1:0]    o_used_count;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [spa_pkg::OBJ_W-1:0]    i_cfg_data = '0;

    // pool model state
    logic [8:0]                 mdl_link [NSLOT];
    logic [NSLOT-1:0]           mdl_alloc;
    logic [NSLOT-1:0]           mdl_keep;
    logic [spa_pkg::MGEN_W-1:0] mdl_gen [NSLOT];
    logic [8:0]                 mdl_head;
    logic [spa_pkg::CNT_W-1:0]  mdl_used;
    logic [spa_pkg::OBJ_W-1:0]  mdl_obj_size;

    t_pool_cmd cmd_backlog [$];
    t_pool_res exp_results [$];
    int        mismatches = 0;
    int        cycle_count = 0;
    int        burst_left = 1;
    int        gap_left = 0;

    // alloc, free live, free any, mark live, mark any, query, clear, sweep, reset, nop
    int mix_weight [3][10] = '{
        '{34, 24, 4, 10, 4, 8, 3, 7, 3, 3},
        '{90, 0, 0, 5, 0, 5, 0, 0, 0, 0},
        '{35, 10, 2, 15, 3, 10, 5, 17, 2, 1}
    };

    slot_pool_allocator_mark_sweep_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_slot_index      (i_slot_index),
        .i_mark_generation (i_mark_generation),
        .i_sweep_limit     (i_sweep_limit),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_granted_slot    (o_granted_slot),
        .o_byte_offset     (o_byte_offset),
        .o_is_kept         (o_is_kept),
        .o_freed_count     (o_freed_count),
        .o_used_count      (o_used_count),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void rebuild_free_list();
        int i;
        for (i = 0; i < NSLOT; i++) begin
            mdl_link[i] = 9'(i + 1);
        end
        mdl_alloc = '0;
        mdl_head  = '0;
        mdl_used  = '0;
    endfunction

    function automatic void release_slot(int s);
        mdl_alloc[s] = 1'b0;
        mdl_used     = mdl_used - 1'b1;
        mdl_link[s]  = mdl_head;
        mdl_head     = 9'(s);
    endfunction

    function automatic t_pool_res apply_pool_cmd(t_pool_cmd c);
        t_pool_res r;
        int s;
        int i;
        int stride;
        r = '0;
        r.status = spa_pkg::ST_OK;
        case (c.op)
            spa_pkg::OP_ALLOC: begin
                if (mdl_head >= NSLOT) begin
                    r.status = spa_pkg::ST_EXHAUSTED;
                end else begin
                    s = mdl_head;
                    mdl_head = mdl_link[s];
                    mdl_alloc[s] = 1'b1;
                    mdl_used = mdl_used + 1'b1;
                    stride = mdl_obj_size;
                    if (stride % ALIGN != 0) begin
                        stride = stride + ALIGN - stride % ALIGN;
                    end
                    r.slot   = spa_pkg::IDX_W'(s);
                    r.offset = spa_pkg::OFF_W'(s * stride);
                end
            end
            spa_pkg::OP_FREE: begin
                if (!mdl_alloc[c.idx]) begin
                    r.status = spa_pkg::ST_BAD_FREE;
                end else begin
                    release_slot(c.idx);
                end
            end
            spa_pkg::OP_MARK: begin
                mdl_keep[c.idx] = 1'b1;
                mdl_gen[c.idx]  = c.gen;
            end
            spa_pkg::OP_QUERY: r.kept = mdl_keep[c.idx];
            spa_pkg::OP_CLEAR: mdl_keep = '0;
            spa_pkg::OP_SWEEP: begin
                for (i = 0; i < NSLOT; i++) begin
                    if (mdl_alloc[i] && !mdl_keep[i] && mdl_gen[i] <= c.lim) begin
                        release_slot(i);
                        r.freed = r.freed + 1'b1;
                    end
                end
            end
            spa_pkg::OP_RESET: rebuild_free_list();
            default: ;
        endcase
        r.used = mdl_used;
        return r;
    endfunction

    function automatic t_pool_cmd cmd(logic [spa_pkg::OP_W-1:0] op,
                                      logic [spa_pkg::IDX_W-1:0] idx,
                                      logic [spa_pkg::MGEN_W-1:0] gen,
                                      logic [spa_pkg::LIMIT_W-1:0] lim);
        t_pool_cmd c;
        c = '0;
        c.op  = op;
        c.idx = idx;
        c.gen = gen;
        c.lim = lim;
        return c;
    endfunction

    function automatic t_pool_cmd rand_pool_cmd(t_mix mix);
        t_pool_cmd c;
        int roll;
        int acc;
        int k;
        int j;
        logic live;
        c = cmd(OP_NOP, spa_pkg::IDX_W'($urandom), spa_pkg::MGEN_W'($urandom),
                spa_pkg::LIMIT_W'($urandom));
        if ($urandom_range(1) == 1) begin
            c.gen = spa_pkg::MGEN_W'($urandom_range(15));
            c.lim = spa_pkg::LIMIT_W'($urandom_range(15));
        end
        roll = $urandom_range(99);
        acc  = 0;
        k    = 9;
        for (j = 0; j < 10; j++) begin
            acc = acc + mix_weight[mix][j];
            if (roll < acc && k == 9) begin
                k = j;
                roll = 1000;
            end
        end
        live = (k == 1 || k == 3);
        case (k)
            0:       c.op = spa_pkg::OP_ALLOC;
            1, 2:    c.op = spa_pkg::OP_FREE;
            3, 4:    c.op = spa_pkg::OP_MARK;
            5:       c.op = spa_pkg::OP_QUERY;
            6:       c.op = spa_pkg::OP_CLEAR;
            7:       c.op = spa_pkg::OP_SWEEP;
            8:       c.op = spa_pkg::OP_RESET;
            default: c.op = OP_NOP;
        endcase
        // steer toward an allocated slot so frees and marks hit live objects
        if (live) begin
            for (j = 0; j < NSLOT; j++) begin
                if (!mdl_alloc[c.idx]) begin
                    c.idx = c.idx + 1'b1;
                end
            end
        end
        return c;
    endfunction

    task automatic enqueue(t_pool_cmd c);
        while (cmd_backlog.size() >= BACKLOG_MAX) begin
            @(posedge i_clk);
        end
        cmd_backlog.push_back(c);
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        logic nxt_start;
        logic nxt_cfg;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            nxt_start = start;
            nxt_cfg   = i_cfg_valid;
            if (start && !busy) begin
                exp_results.push_back(apply_pool_cmd(cmd_backlog.pop_front()));
                nxt_start = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                mdl_obj_size = i_cfg_data;
                void'(cmd_backlog.pop_front());
                nxt_cfg = 1'b0;
            end
            if (!nxt_start && !nxt_cfg && cmd_backlog.size() != 0) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                end else if (cmd_backlog[0].is_cfg) begin
                    if (exp_results.size() == 0) begin
                        i_cfg_data <= cmd_backlog[0].obj_size;
                        nxt_cfg = 1'b1;
                    end
                end else begin
                    i_opcode          <= cmd_backlog[0].op;
                    i_slot_index      <= cmd_backlog[0].idx;
                    i_mark_generation <= cmd_backlog[0].gen;
                    i_sweep_limit     <= cmd_backlog[0].lim;
                    nxt_start = 1'b1;
                    burst_left = burst_left - 1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            start       <= nxt_start;
            i_cfg_valid <= nxt_cfg;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_pool_res want;
        if (i_rst_n && o_done) begin
            if (exp_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected result beat, expected none, actual status %0d",
                         $time, o_status);
            end else begin
                want = exp_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("granted_slot", want.slot, o_granted_slot);
                check_field("byte_offset", want.offset, o_byte_offset);
                check_field("is_kept", want.kept, o_is_kept);
                check_field("freed_count", want.freed, o_freed_count);
                check_field("used_count", want.used, o_used_count);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int p;
        int n;
        int phase_obj [8];
        t_mix phase_mix [8];
        t_pool_cmd c;
        phase_obj = '{4096, 1, 8191, 0, 17, 0, 4095, 16};
        phase_mix = '{MIX_FILL, MIX_BALANCED, MIX_FILL, MIX_BALANCED,
                      MIX_RECLAIM, MIX_BALANCED, MIX_RECLAIM, MIX_FILL};
        phase_obj[5] = $urandom_range(1, 4096);

        rebuild_free_list();
        mdl_keep = '0;
        for (n = 0; n < NSLOT; n++) begin
            mdl_gen[n] = '0;
        end
        mdl_obj_size = spa_pkg::OBJ_RESET;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default object size
        enqueue(cmd(spa_pkg::OP_QUERY, 8'd0,   16'hFFFF, 16'hFFFF));
        enqueue(cmd(spa_pkg::OP_ALLOC, 8'hFF,  16'hFFFF, 16'h0000));
        enqueue(cmd(spa_pkg::OP_ALLOC, 8'h00,  16'h0000, 16'hFFFF));
        enqueue(cmd(spa_pkg::OP_MARK,  8'd0,   16'hFFFF, 16'h0000));
        enqueue(cmd(spa_pkg::OP_MARK,  8'd255, 16'h0000, 16'hFFFF));
        enqueue(cmd(spa_pkg::OP_QUERY, 8'd0,   16'h0000, 16'h0000));
        enqueue(cmd(spa_pkg::OP_QUERY, 8'd255, 16'h0000, 16'h0000));
        enqueue(cmd(spa_pkg::OP_FREE,  8'd200, 16'h0000, 16'h0000));
        enqueue(cmd(spa_pkg::OP_FREE,  8'd1,   16'h0000, 16'h0000));
        enqueue(cmd(spa_pkg::OP_ALLOC, 8'd0,   16'h0000, 16'h0000));
        enqueue(cmd(OP_NOP,            8'hFF,  16'hFFFF, 16'hFFFF));
        enqueue(cmd(spa_pkg::OP_SWEEP, 8'd0,   16'h0000, 16'hFFFF));
        enqueue(cmd(spa_pkg::OP_SWEEP, 8'd0,   16'h0000, 16'h0000));
        enqueue(cmd(spa_pkg::OP_CLEAR, 8'hFF,  16'hFFFF, 16'hFFFF));
        enqueue(cmd(spa_pkg::OP_SWEEP, 8'd0,   16'h0000, 16'hFFFE));
        enqueue(cmd(spa_pkg::OP_SWEEP, 8'd0,   16'h0000, 16'hFFFF));
        enqueue(cmd(spa_pkg::OP_ALLOC, 8'd0,   16'h0000, 16'h0000));
        enqueue(cmd(spa_pkg::OP_ALLOC, 8'd0,   16'h0000, 16'h0000));
        enqueue(cmd(spa_pkg::OP_MARK,  8'd0,   16'd5,    16'h0000));
        enqueue(cmd(spa_pkg::OP_RESET, 8'hFF,  16'hFFFF, 16'hFFFF));
        enqueue(cmd(spa_pkg::OP_QUERY, 8'd0,   16'h0000, 16'h0000));
        enqueue(cmd(spa_pkg::OP_ALLOC, 8'd0,   16'h0000, 16'h0000));
        enqueue(cmd(spa_pkg::OP_QUERY, 8'd0,   16'h0000, 16'h0000));
        enqueue(cmd(spa_pkg::OP_FREE,  8'd0,   16'h0000, 16'h0000));

        for (p = 0; p < 8; p++) begin
            c = '0;
            c.is_cfg   = 1'b1;
            c.obj_size = spa_pkg::OBJ_W'(phase_obj[p]);
            enqueue(c);
            for (n = 0; n < ((phase_mix[p] == MIX_FILL) ? 300 : 210); n++) begin
                enqueue(rand_pool_cmd(phase_mix[p]));
            end
        end

        while (cmd_backlog.size() != 0 || start || i_cfg_valid || exp_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
